// ===== hw/rtl/lubw_pkg.sv =====
// ----------------------------------------------------------------------------
// lubw_pkg
// Shared widths and constants for the longest unique byte window block.
// ----------------------------------------------------------------------------
package lubw_pkg;

  // Width of one character and the number of distinct byte values.
  localparam int unsigned ByteW      = 8;
  localparam int unsigned NumSymbols = 256;

  // Window length: a run of distinct bytes is at most 256 long.
  localparam int unsigned LenW   = 9;
  localparam int unsigned LenMax = 256;

  // Width of the reported start position.
  localparam int unsigned StartW = 16;

endpackage

// ===== hw/rtl/lubw_in_if.sv =====
// ----------------------------------------------------------------------------
// lubw_in_if
// Input channel: one byte of the string per item, with its flags.
// ----------------------------------------------------------------------------
interface lubw_in_if;
  import lubw_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  byte_value;
  logic              no_byte;
  logic              end_of_string;

  modport source (
    output valid, byte_value, no_byte, end_of_string,
    input  ready
  );

  modport sink (
    input  valid, byte_value, no_byte, end_of_string,
    output ready
  );

endinterface

// ===== hw/rtl/lubw_out_if.sv =====
// ----------------------------------------------------------------------------
// lubw_out_if
// Result channel: start and length of the best window of one string.
// ----------------------------------------------------------------------------
interface lubw_out_if;
  import lubw_pkg::*;

  logic              valid;
  logic              ready;
  logic [StartW-1:0] best_start;
  logic [LenW-1:0]   best_length;
  logic              overflow;

  modport source (
    output valid, best_start, best_length, overflow,
    input  ready
  );

  modport sink (
    input  valid, best_start, best_length, overflow,
    output ready
  );

endinterface

// ===== hw/rtl/lubw_ram.sv =====
// ----------------------------------------------------------------------------
// lubw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lubw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered and held until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/longest_unique_byte_window_top.sv =====
// ----------------------------------------------------------------------------
// longest_unique_byte_window_top
// Finds the first longest run of distinct bytes in a streamed byte string.
// ----------------------------------------------------------------------------
// The block takes one byte per item and per clock cycle, and items of the
// following string may follow the last item of a string without a gap. Each
// item first reads the last-position RAM on accept, then updates the window
// state and writes the RAM back in the update stage; a write in the same
// cycle as the next read to the same byte is forwarded. The result of a
// string is loaded into the output register when its last item leaves the
// update stage. Input is held off only while a last item waits for a result
// still untaken at the output. Positions count from 0; at 2^POS_WIDTH - 1
// they saturate and the result is flagged with overflow.
module longest_unique_byte_window_top #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lubw_in_if.sink    in_i,
  lubw_out_if.source out_o
);
  import lubw_pkg::*;

  localparam logic [POS_WIDTH-1:0] PosMax = '1;
  localparam logic [POS_WIDTH:0]   LenMaxWide = (POS_WIDTH+1)'(LenMax);

  // Handshake and stage control.
  logic in_accept;
  logic out_free;
  logic s1_fire;
  logic s1_valid_q, s1_valid_d;

  // Item held in the update stage.
  logic [ByteW-1:0]     s1_byte_q;
  logic                 s1_no_byte_q;
  logic                 s1_last_q;
  logic                 fwd_hit_q;
  logic [POS_WIDTH-1:0] fwd_data_q;

  // Per-string window state.
  logic [NumSymbols-1:0] seen_q, seen_d;
  logic [POS_WIDTH-1:0]  win_start_q, win_start_d;
  logic [POS_WIDTH-1:0]  pos_count_q, pos_count_d;
  logic [POS_WIDTH-1:0]  best_start_q, best_start_d;
  logic [LenW-1:0]       best_len_q, best_len_d;
  logic                  ovf_q, ovf_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [StartW-1:0]    out_start_q;
  logic [LenW-1:0]      out_len_q;
  logic                 out_ovf_q;

  // RAM ports.
  logic                 ram_we;
  logic [POS_WIDTH-1:0] ram_rdata;

  // Update-stage datapath.
  logic                 has_byte;
  logic                 pos_sat;
  logic [POS_WIDTH-1:0] last_pos;
  logic                 repeat_hit;
  logic [POS_WIDTH-1:0] next_start;
  logic [POS_WIDTH-1:0] diff1;
  logic [LenW-1:0]      span1;
  logic                 take1;
  logic [POS_WIDTH-1:0] best_start1;
  logic [LenW-1:0]      best_len1;
  logic [POS_WIDTH-1:0] win_start1;
  logic [POS_WIDTH:0]   end_pos;
  logic [POS_WIDTH:0]   start_wide;
  logic [POS_WIDTH:0]   diff2;
  logic [LenW-1:0]      span2;
  logic                 take2;
  logic [POS_WIDTH-1:0] best_start2;
  logic [LenW-1:0]      best_len2;
  logic                 ovf_now;

  // Handshake: the update stage moves on unless a last item finds the
  // output register still occupied.
  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_fire   = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_accept = in_i.valid && in_i.ready;

  // Last-position table: read on accept, written back from the update stage.
  assign ram_we = s1_fire && has_byte;

  lubw_ram #(
    .Width (POS_WIDTH),
    .Depth (NumSymbols)
  ) u_last_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_byte_q),
    .wdata_i (pos_count_q),
    .re_i    (in_accept),
    .raddr_i (in_i.byte_value),
    .rdata_o (ram_rdata)
  );

  // Stage valid bit.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  // Item payload, plus the forwarded write that the RAM read would miss.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q    <= in_i.byte_value;
      s1_no_byte_q <= in_i.no_byte;
      s1_last_q    <= in_i.end_of_string;
      fwd_hit_q    <= ram_we && (s1_byte_q == in_i.byte_value);
      fwd_data_q   <= pos_count_q;
    end
  end

  // Window update for the item in the update stage.
  always_comb begin
    has_byte = !s1_no_byte_q;
    pos_sat  = (pos_count_q == PosMax);
    ovf_now  = has_byte && pos_sat;
    last_pos = fwd_hit_q ? fwd_data_q : ram_rdata;

    // A repeat inside the window closes the window before this byte.
    repeat_hit = has_byte && seen_q[s1_byte_q] && (last_pos >= win_start_q);
    next_start = (last_pos == PosMax) ? PosMax : last_pos + 1'b1;

    diff1 = pos_count_q - win_start_q;
    if (pos_count_q < win_start_q) begin
      span1 = '0;
    end else if ({1'b0, diff1} > LenMaxWide) begin
      span1 = LenW'(LenMax);
    end else begin
      span1 = LenW'(diff1);
    end

    take1       = repeat_hit && (span1 > best_len_q);
    best_start1 = take1 ? win_start_q : best_start_q;
    best_len1   = take1 ? span1 : best_len_q;
    win_start1  = repeat_hit ? next_start : win_start_q;

    // On the last item the final window is offered as well.
    end_pos    = has_byte ? ({1'b0, pos_count_q} + 1'b1) : {1'b0, pos_count_q};
    start_wide = {1'b0, win_start1};
    diff2      = end_pos - start_wide;
    if (end_pos < start_wide) begin
      span2 = '0;
    end else if (diff2 > LenMaxWide) begin
      span2 = LenW'(LenMax);
    end else begin
      span2 = LenW'(diff2);
    end

    take2 = s1_last_q && ((pos_count_q != '0) || has_byte) && (span2 > best_len1);
    best_start2 = take2 ? win_start1 : best_start1;
    best_len2   = take2 ? span2 : best_len1;
  end

  // Next values of the string state; a last item clears it for the next one.
  always_comb begin
    seen_d       = seen_q;
    win_start_d  = win_start_q;
    pos_count_d  = pos_count_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    ovf_d        = ovf_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        seen_d       = '0;
        win_start_d  = '0;
        pos_count_d  = '0;
        best_start_d = '0;
        best_len_d   = '0;
        ovf_d        = 1'b0;
      end else begin
        if (has_byte) begin
          seen_d[s1_byte_q] = 1'b1;
          pos_count_d       = pos_sat ? pos_count_q : pos_count_q + 1'b1;
        end
        win_start_d  = win_start1;
        best_start_d = best_start1;
        best_len_d   = best_len1;
        ovf_d        = ovf_q || ovf_now;
      end
    end
  end

  // Output register valid bit.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_start_q <= StartW'(best_start2);
      out_len_q   <= best_len2;
      out_ovf_q   <= ovf_q || ovf_now;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      seen_q       <= '0;
      win_start_q  <= '0;
      pos_count_q  <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      ovf_q        <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      seen_q       <= seen_d;
      win_start_q  <= win_start_d;
      pos_count_q  <= pos_count_d;
      best_start_q <= best_start_d;
      best_len_q   <= best_len_d;
      ovf_q        <= ovf_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.best_start  = out_start_q;
  assign out_o.best_length = out_len_q;
  assign out_o.overflow    = out_ovf_q;

endmodule

// ===== dv/longest_unique_byte_window_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_unique_byte_window_top_tb
// Self-checking bench for the longest unique byte window block.
// ----------------------------------------------------------------------------
// Strings are streamed into the block one byte per item. Each accepted item
// is fed to a local sliding-window tracker that keeps its own last-position
// table and best window, and every string end queues the window the block
// should report. Returned windows are compared field by field in order.
// The stimulus covers empty strings, ignored items and flagged endings,
// repeats inside and outside the window and long cyclic strings.
// ----------------------------------------------------------------------------
module longest_unique_byte_window_top_tb;
  import lubw_pkg::*;

  // Position counter width of the instance under test.
  localparam int unsigned PosW = 16;
  localparam bit [PosW-1:0] PosMax = '1;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 10;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             no_byte;
    logic             end_of_string;
  } string_item_t;

  typedef struct packed {
    logic [StartW-1:0] best_start;
    logic [LenW-1:0]   best_length;
    logic              overflow;
  } window_result_t;

  // Tracks the best window of the current string and holds the windows
  // that the block still owes.
  class window_board;
    bit [PosW-1:0]   last_pos [NumSymbols];
    bit              seen     [NumSymbols];
    bit [PosW-1:0]   win_start;
    bit [PosW-1:0]   pos_count;
    bit [PosW-1:0]   best_start;
    bit [LenW-1:0]   best_len;
    bit              ovf_flag;
    window_result_t  expected_windows [$];
    int unsigned     errors;

    function void clear_string();
      foreach (seen[i]) seen[i] = 1'b0;
      win_start = '0;
      pos_count = '0;
      best_start = '0;
      best_len = '0;
      ovf_flag = 1'b0;
    endfunction

    // Length of [from_pos, to_pos), zero when reversed and clamped to 256.
    function bit [LenW-1:0] clamp_span(bit [PosW:0] from_pos, bit [PosW:0] to_pos);
      bit [PosW:0] n;
      n = (to_pos >= from_pos) ? to_pos - from_pos : '0;
      if (n > LenMax) return LenW'(LenMax);
      return LenW'(n);
    endfunction

    // Strict compare keeps the first of equally long windows.
    function void offer(bit [PosW-1:0] start_pos, bit [LenW-1:0] len);
      if (len > best_len) begin
        best_len = len;
        best_start = start_pos;
      end
    endfunction

    function void take_item(string_item_t it);
      bit [PosW-1:0] pos;
      bit [PosW:0]   next_start;
      bit [PosW:0]   stop;
      window_result_t res;
      if (!it.no_byte) begin
        pos = pos_count;
        if (pos == PosMax) ovf_flag = 1'b1;
        // A repeat inside the window closes it and restarts past the copy.
        if (seen[it.byte_value] && last_pos[it.byte_value] >= win_start) begin
          next_start = {1'b0, last_pos[it.byte_value]} + 1'b1;
          offer(win_start, clamp_span({1'b0, win_start}, {1'b0, pos}));
          win_start = (next_start > PosMax) ? PosMax : next_start[PosW-1:0];
        end
        last_pos[it.byte_value] = pos;
        seen[it.byte_value] = 1'b1;
        pos_count = (pos < PosMax) ? pos + 1'b1 : PosMax;
        stop = {1'b0, pos} + 1'b1;
      end else begin
        stop = {1'b0, pos_count};
      end
      if (!it.end_of_string) return;
      if (pos_count != 0 || !it.no_byte) begin
        offer(win_start, clamp_span({1'b0, win_start}, stop));
      end
      res.best_start = StartW'(best_start);
      res.best_length = best_len;
      res.overflow = ovf_flag;
      expected_windows.insert(expected_windows.size(), res);
      clear_string();
    endfunction

    function void check_window(window_result_t got);
      window_result_t want;
      if (expected_windows.size() == 0) begin
        $display("%0t: unexpected window start %0d length %0d overflow %0d", $time,
                 got.best_start, got.best_length, got.overflow);
        errors++;
        return;
      end
      want = expected_windows.pop_front();
      if (got.best_start !== want.best_start) begin
        $display("%0t: best_start expected %0d, got %0d", $time,
                 want.best_start, got.best_start);
        errors++;
      end
      if (got.best_length !== want.best_length) begin
        $display("%0t: best_length expected %0d, got %0d", $time,
                 want.best_length, got.best_length);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %0d, got %0d", $time,
                 want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lubw_in_if  in_bus ();
  lubw_out_if out_bus ();

  longest_unique_byte_window_top #(
    .POS_WIDTH(PosW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  window_board board = new();
  string_item_t directed_items [$];
  int unsigned src_idle_pct = 8;
  int unsigned snk_stall_pct = 66;
  int unsigned counted_items = 0;
  int unsigned quiet_cycles = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Check every window the block hands over.
  always @(posedge clk_i) begin
    window_result_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.best_start = out_bus.best_start;
      got.best_length = out_bus.best_length;
      got.overflow = out_bus.overflow;
      board.check_window(got);
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic string_item_t mk(int unsigned b, bit nb, bit eos);
    string_item_t it;
    it.byte_value = ByteW'(b);
    it.no_byte = nb;
    it.end_of_string = eos;
    return it;
  endfunction

  // Append one item to the directed sequence.
  function automatic void add_directed(string_item_t it);
    directed_items.insert(directed_items.size(), it);
  endfunction

  // Offer one item, with random gaps before it, and wait until it is taken.
  task automatic drive_item(input string_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.byte_value <= it.byte_value;
    in_bus.no_byte <= it.no_byte;
    in_bus.end_of_string <= it.end_of_string;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    board.take_item(it);
    counted_items++;
  endtask

  // Byte i of a string; ignored items slip in between now and then.
  task automatic drive_byte(input int unsigned b, input bit eos);
    if ($urandom_range(0, 99) < 5) drive_item(mk($urandom_range(0, 255), 1'b1, 1'b0));
    drive_item(mk(b, 1'b0, eos));
  endtask

  // One random string: empty, long and nearly cyclic, or short over an
  // alphabet of 2 to 256 bytes, mostly narrow so that repeats are frequent.
  task automatic run_string();
    int unsigned kind;
    int unsigned len;
    int unsigned base;
    int unsigned span_k;
    int unsigned step;
    int unsigned b;
    bit flag_end;
    kind = $urandom_range(0, 99);
    base = $urandom_range(0, 255);
    flag_end = ($urandom_range(0, 99) < 20);
    if (kind < 5) begin
      drive_item(mk($urandom_range(0, 255), 1'b1, 1'b1));
    end else if (kind < 8) begin
      len = $urandom_range(200, 600);
      step = 2 * $urandom_range(0, 127) + 1;
      for (int unsigned i = 0; i < len; i++) begin
        b = (base + i * step) % 256;
        if ($urandom_range(0, 99) < 2) b = $urandom_range(0, 255);
        drive_byte(b, !flag_end && (i == len - 1));
      end
      if (flag_end) drive_item(mk($urandom_range(0, 255), 1'b1, 1'b1));
    end else begin
      len = $urandom_range(1, 40);
      span_k = $urandom_range(0, 99);
      if (span_k < 50) span_k = $urandom_range(2, 8);
      else if (span_k < 80) span_k = $urandom_range(9, 40);
      else span_k = $urandom_range(41, 256);
      for (int unsigned i = 0; i < len; i++) begin
        b = (base + $urandom_range(0, span_k - 1)) % 256;
        drive_byte(b, !flag_end && (i == len - 1));
      end
      if (flag_end) drive_item(mk($urandom_range(0, 255), 1'b1, 1'b1));
    end
  endtask

  // Stimulus.
  initial begin
    rst_ni = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.byte_value <= '0;
    in_bus.no_byte <= 1'b0;
    in_bus.end_of_string <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty string ended by an item without a byte.
    add_directed(mk(8'hA5, 1'b1, 1'b1));
    // Single bytes at both extremes.
    add_directed(mk(0, 1'b0, 1'b1));
    add_directed(mk(255, 1'b0, 1'b1));
    // Repeat of the same byte with an ignored item in between.
    add_directed(mk(255, 1'b0, 1'b0));
    add_directed(mk(8'h5A, 1'b1, 1'b0));
    add_directed(mk(255, 1'b0, 1'b1));
    // Of two equally long windows the first is kept; a longer final window wins.
    add_directed(mk(1, 1'b0, 1'b0));
    add_directed(mk(2, 1'b0, 1'b0));
    add_directed(mk(3, 1'b0, 1'b0));
    add_directed(mk(1, 1'b0, 1'b0));
    add_directed(mk(2, 1'b0, 1'b0));
    add_directed(mk(4, 1'b0, 1'b1));
    // String closed by an item without a byte.
    add_directed(mk(7, 1'b0, 1'b0));
    add_directed(mk(8, 1'b0, 1'b0));
    add_directed(mk(8'hFF, 1'b1, 1'b1));
    // The final window is the longest one.
    add_directed(mk(5, 1'b0, 1'b0));
    add_directed(mk(5, 1'b0, 1'b0));
    add_directed(mk(6, 1'b0, 1'b0));
    add_directed(mk(128, 1'b0, 1'b1));
    // A repeat whose earlier copy lies before the window start.
    add_directed(mk(9, 1'b0, 1'b0));
    add_directed(mk(10, 1'b0, 1'b0));
    add_directed(mk(10, 1'b0, 1'b0));
    add_directed(mk(9, 1'b0, 1'b1));
    foreach (directed_items[i]) drive_item(directed_items[i]);

    // Random strings under three idling patterns.
    while (counted_items < 350) run_string();
    src_idle_pct = 66;
    snk_stall_pct = 8;
    while (counted_items < 700) run_string();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    while (counted_items < 1030) run_string();
    in_bus.valid <= 1'b0;

    // Drain the remaining windows, then allow the pipeline to settle.
    while (board.expected_windows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.expected_windows.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lubw_pkg.sv
hw/rtl/lubw_in_if.sv
hw/rtl/lubw_out_if.sv
hw/rtl/lubw_ram.sv
hw/rtl/longest_unique_byte_window_top.sv
dv/longest_unique_byte_window_top_tb.sv
